// ===== hdl/uled_pkg.sv =====
// Package for the terminal line editor with echo.
// Holds character codes, controller states, and the controller/datapath command types.
// No dependencies.
`timescale 1ns / 1ps

package uled_pkg;

    localparam int LINE_LEN_DEF = 32;
    localparam int BYTE_W       = 8;

    localparam logic [BYTE_W-1:0] CODE_CR = 8'd13;
    localparam logic [BYTE_W-1:0] CODE_BS = 8'd8;
    localparam logic [BYTE_W-1:0] CODE_LF = 8'd10;
    localparam logic [BYTE_W-1:0] CODE_SP = 8'd32;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_ECHO,
        ST_ER_BS1,
        ST_ER_SP1,
        ST_ER_SP2,
        ST_ER_BS2,
        ST_ER_RAW,
        ST_CR_LF,
        ST_CR_CR,
        ST_RD_REQ,
        ST_RD_EMIT,
        ST_TR_CRS,
        ST_TR_CR,
        ST_TR_LF
    } t_state;

    typedef enum logic [2:0] {
        SEL_RX,
        SEL_LF,
        SEL_CR,
        SEL_SP,
        SEL_BS,
        SEL_RAM
    } t_sel;

    typedef struct packed {
        logic in_ready;
        logic capture;
        logic emit;
        t_sel sel;
        logic copy;
        logic last;
        logic ram_we;
        logic idx_inc;
        logic idx_dec;
        logic idx_clr;
        logic ptr_clr;
        logic ptr_inc;
        logic re;
        logic rd_sel_next;
    } t_cmd;

    typedef struct packed {
        logic slot_free;
        logic is_cr;
        logic is_bs;
        logic idx_zero;
        logic idx_full;
        logic ptr_at_idx;
        logic ptr_nx_at_idx;
        logic rd_zero;
    } t_status;

endpackage

// ===== hdl/uart_line_editor_echo_core.sv =====
// Top level of the terminal line editor with echo.
// Depends on uled_pkg, uled_ctrl, uled_dp and uled_ram.
//
// Usage: received terminal bytes enter on the rx channel (i_rx_valid, o_rx_ready,
// i_rx_byte); every byte produces a run of transmit bytes on the tx channel
// (o_tx_valid, i_tx_ready, o_tx_byte, o_line_copy, o_last_of_run). The last
// byte of each run carries o_last_of_run.
// One byte is handled at a time. The input is registered and decoded, and the
// first result goes to the output register from the state after decode.
// Echo runs: an ordinary byte gives itself; a backspace past index zero gives
// BS, SP, SP, BS, itself; a carriage return LF, CR, the line replay, CR, LF.
// Replay: one byte per cycle, set by the line memory read port, unless held.
// A stalled receiver holds the output register; the sequencer waits and
// resumes when the transfer completes. The next input can be taken while the
// final result of a run still waits in the output register.
// Reset clears the write index, the controller and the output valid; the
// line memory needs no clearing.
`timescale 1ns / 1ps

module uart_line_editor_echo_core #(
    parameter int LINE_LEN = uled_pkg::LINE_LEN_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_rx_valid,
    output logic                        o_rx_ready,
    input  logic [uled_pkg::BYTE_W-1:0] i_rx_byte,
    output logic                        o_tx_valid,
    input  logic                        i_tx_ready,
    output logic [uled_pkg::BYTE_W-1:0] o_tx_byte,
    output logic                        o_line_copy,
    output logic                        o_last_of_run
);

    uled_pkg::t_cmd    w_cmd;
    uled_pkg::t_status w_status;

    uled_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rx_valid (i_rx_valid),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    uled_dp #(
        .LINE_LEN (LINE_LEN)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_rx_byte     (i_rx_byte),
        .i_tx_ready    (i_tx_ready),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .o_tx_valid    (o_tx_valid),
        .o_tx_byte     (o_tx_byte),
        .o_line_copy   (o_line_copy),
        .o_last_of_run (o_last_of_run)
    );

    assign o_rx_ready = w_cmd.in_ready;

endmodule

// ===== hdl/uled_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module uled_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                                 i_clk,
    input  logic                                 i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                     i_wdata,
    input  logic                                 i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                     o_rdata
);

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/uled_ctrl.sv =====
// Controller state machine of the line editor.
// Depends on uled_pkg; drives the datapath through a command struct.
`timescale 1ns / 1ps

module uled_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_rx_valid,
    input  uled_pkg::t_status i_status,
    output uled_pkg::t_cmd    o_cmd
);

    uled_pkg::t_state r_state;
    uled_pkg::t_state n_state;
    uled_pkg::t_cmd   w_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= uled_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            uled_pkg::ST_IDLE: begin
                if (i_rx_valid) n_state = uled_pkg::ST_DECODE;
            end
            uled_pkg::ST_DECODE: begin
                if (i_status.is_cr) begin
                    n_state = uled_pkg::ST_CR_LF;
                end else if (i_status.is_bs && !i_status.idx_zero) begin
                    n_state = uled_pkg::ST_ER_BS1;
                end else begin
                    n_state = uled_pkg::ST_ECHO;
                end
            end
            uled_pkg::ST_ECHO: if (i_status.slot_free) n_state = uled_pkg::ST_IDLE;
            uled_pkg::ST_ER_BS1: if (i_status.slot_free) n_state = uled_pkg::ST_ER_SP1;
            uled_pkg::ST_ER_SP1: if (i_status.slot_free) n_state = uled_pkg::ST_ER_SP2;
            uled_pkg::ST_ER_SP2: if (i_status.slot_free) n_state = uled_pkg::ST_ER_BS2;
            uled_pkg::ST_ER_BS2: if (i_status.slot_free) n_state = uled_pkg::ST_ER_RAW;
            uled_pkg::ST_ER_RAW: if (i_status.slot_free) n_state = uled_pkg::ST_IDLE;
            uled_pkg::ST_CR_LF: if (i_status.slot_free) n_state = uled_pkg::ST_CR_CR;
            uled_pkg::ST_CR_CR: if (i_status.slot_free) n_state = uled_pkg::ST_RD_REQ;
            uled_pkg::ST_RD_REQ: begin
                if (i_status.ptr_at_idx) begin
                    n_state = uled_pkg::ST_TR_CRS;
                end else begin
                    n_state = uled_pkg::ST_RD_EMIT;
                end
            end
            uled_pkg::ST_RD_EMIT: begin
                if (i_status.rd_zero) begin
                    n_state = uled_pkg::ST_TR_CR;
                end else if (i_status.slot_free && i_status.ptr_nx_at_idx) begin
                    n_state = uled_pkg::ST_TR_CRS;
                end
            end
            uled_pkg::ST_TR_CRS: if (i_status.slot_free) n_state = uled_pkg::ST_TR_CR;
            uled_pkg::ST_TR_CR: if (i_status.slot_free) n_state = uled_pkg::ST_TR_LF;
            uled_pkg::ST_TR_LF: if (i_status.slot_free) n_state = uled_pkg::ST_IDLE;
            default: n_state = uled_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        w_cmd      = '0;
        w_cmd.sel  = uled_pkg::SEL_RX;
        case (r_state)
            uled_pkg::ST_IDLE: begin
                w_cmd.in_ready = 1'b1;
                w_cmd.capture  = i_rx_valid;
            end
            uled_pkg::ST_DECODE: begin
                if (i_status.is_cr) begin
                    w_cmd.ptr_clr = 1'b1;
                end else if (i_status.is_bs && !i_status.idx_zero) begin
                    w_cmd.idx_dec = 1'b1;
                end else if (!i_status.idx_full) begin
                    w_cmd.ram_we  = 1'b1;
                    w_cmd.idx_inc = 1'b1;
                end
            end
            uled_pkg::ST_ECHO, uled_pkg::ST_ER_RAW: begin
                w_cmd.emit = i_status.slot_free;
                w_cmd.sel  = uled_pkg::SEL_RX;
                w_cmd.last = 1'b1;
            end
            uled_pkg::ST_ER_BS1, uled_pkg::ST_ER_BS2: begin
                w_cmd.emit = i_status.slot_free;
                w_cmd.sel  = uled_pkg::SEL_BS;
            end
            uled_pkg::ST_ER_SP1, uled_pkg::ST_ER_SP2: begin
                w_cmd.emit = i_status.slot_free;
                w_cmd.sel  = uled_pkg::SEL_SP;
            end
            uled_pkg::ST_CR_LF: begin
                w_cmd.emit = i_status.slot_free;
                w_cmd.sel  = uled_pkg::SEL_LF;
            end
            uled_pkg::ST_CR_CR: begin
                w_cmd.emit = i_status.slot_free;
                w_cmd.sel  = uled_pkg::SEL_CR;
            end
            uled_pkg::ST_RD_REQ: begin
                w_cmd.re = !i_status.ptr_at_idx;
            end
            uled_pkg::ST_RD_EMIT: begin
                if (!i_status.rd_zero && i_status.slot_free) begin
                    w_cmd.emit        = 1'b1;
                    w_cmd.sel         = uled_pkg::SEL_RAM;
                    w_cmd.copy        = 1'b1;
                    w_cmd.ptr_inc     = 1'b1;
                    w_cmd.re          = !i_status.ptr_nx_at_idx;
                    w_cmd.rd_sel_next = 1'b1;
                end
            end
            uled_pkg::ST_TR_CRS, uled_pkg::ST_TR_CR: begin
                w_cmd.emit = i_status.slot_free;
                w_cmd.sel  = uled_pkg::SEL_CR;
                w_cmd.copy = 1'b1;
            end
            uled_pkg::ST_TR_LF: begin
                w_cmd.emit    = i_status.slot_free;
                w_cmd.sel     = uled_pkg::SEL_LF;
                w_cmd.copy    = 1'b1;
                w_cmd.last    = 1'b1;
                w_cmd.idx_clr = i_status.slot_free;
            end
            default: begin
                w_cmd = '0;
            end
        endcase
    end

    assign o_cmd = w_cmd;

    // A transfer in always leads to the decode step.
    a_accept_decode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rx_valid && w_cmd.in_ready) |=> (r_state == uled_pkg::ST_DECODE))
        else $error("accepted byte did not reach decode");

endmodule

// ===== hdl/uled_dp.sv =====
// Datapath of the line editor: input byte, write index, replay pointer, output register.
// Depends on uled_pkg and uled_ram; steered by the command struct from uled_ctrl.
`timescale 1ns / 1ps

module uled_dp #(
    parameter int LINE_LEN = uled_pkg::LINE_LEN_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [uled_pkg::BYTE_W-1:0] i_rx_byte,
    input  logic                        i_tx_ready,
    input  uled_pkg::t_cmd              i_cmd,
    output uled_pkg::t_status           o_status,
    output logic                        o_tx_valid,
    output logic [uled_pkg::BYTE_W-1:0] o_tx_byte,
    output logic                        o_line_copy,
    output logic                        o_last_of_run
);

    localparam int IW = $clog2(LINE_LEN + 1);
    localparam int AW = (LINE_LEN > 1) ? $clog2(LINE_LEN) : 1;

    logic [uled_pkg::BYTE_W-1:0] r_byte;
    logic [IW-1:0]               r_idx;
    logic [IW-1:0]               r_ptr;
    logic [IW-1:0]               w_ptr_nx;
    logic [IW-1:0]               w_raddr;
    logic [uled_pkg::BYTE_W-1:0] w_rdata;
    logic [uled_pkg::BYTE_W-1:0] w_out_byte;
    logic                        r_out_valid;
    logic [uled_pkg::BYTE_W-1:0] r_out_byte;
    logic                        r_out_copy;
    logic                        r_out_last;
    logic                        w_slot_free;

    assign w_ptr_nx    = r_ptr + 1'b1;
    assign w_raddr     = i_cmd.rd_sel_next ? w_ptr_nx : r_ptr;
    assign w_slot_free = !r_out_valid || i_tx_ready;

    uled_ram #(
        .WIDTH (uled_pkg::BYTE_W),
        .DEPTH (LINE_LEN)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.ram_we),
        .i_waddr (r_idx[AW-1:0]),
        .i_wdata (r_byte),
        .i_re    (i_cmd.re),
        .i_raddr (w_raddr[AW-1:0]),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_byte <= i_rx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
            r_ptr <= '0;
        end else begin
            if (i_cmd.idx_clr) begin
                r_idx <= '0;
            end else if (i_cmd.idx_inc) begin
                r_idx <= r_idx + 1'b1;
            end else if (i_cmd.idx_dec) begin
                r_idx <= r_idx - 1'b1;
            end
            if (i_cmd.ptr_clr) begin
                r_ptr <= '0;
            end else if (i_cmd.ptr_inc) begin
                r_ptr <= w_ptr_nx;
            end
        end
    end

    always_comb begin
        case (i_cmd.sel)
            uled_pkg::SEL_RX:  w_out_byte = r_byte;
            uled_pkg::SEL_LF:  w_out_byte = uled_pkg::CODE_LF;
            uled_pkg::SEL_CR:  w_out_byte = uled_pkg::CODE_CR;
            uled_pkg::SEL_SP:  w_out_byte = uled_pkg::CODE_SP;
            uled_pkg::SEL_BS:  w_out_byte = uled_pkg::CODE_BS;
            uled_pkg::SEL_RAM: w_out_byte = w_rdata;
            default:           w_out_byte = r_byte;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_tx_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_byte <= w_out_byte;
            r_out_copy <= i_cmd.copy;
            r_out_last <= i_cmd.last;
        end
    end

    assign o_status.slot_free     = w_slot_free;
    assign o_status.is_cr         = (r_byte == uled_pkg::CODE_CR);
    assign o_status.is_bs         = (r_byte == uled_pkg::CODE_BS);
    assign o_status.idx_zero      = (r_idx == '0);
    assign o_status.idx_full      = (r_idx == IW'(LINE_LEN));
    assign o_status.ptr_at_idx    = (r_ptr == r_idx);
    assign o_status.ptr_nx_at_idx = (w_ptr_nx == r_idx);
    assign o_status.rd_zero       = (w_rdata == '0);

    assign o_tx_valid    = r_out_valid;
    assign o_tx_byte     = r_out_byte;
    assign o_line_copy   = r_out_copy;
    assign o_last_of_run = r_out_last;

    // The write index never passes the line capacity.
    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= IW'(LINE_LEN))
        else $error("write index beyond line capacity");

    // Stores and replay reads stay inside the line memory.
    a_ram_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.ram_we |-> (r_idx < IW'(LINE_LEN))) and
        (i_cmd.re |-> (w_raddr < IW'(LINE_LEN))))
        else $error("line memory access out of range");

    // A new result is loaded only when the output register is free.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> w_slot_free)
        else $error("output register overwritten before transfer");

endmodule

// ===== sim/uart_line_editor_echo_core_tb.sv =====
// Testbench for uart_line_editor_echo_core: drives received bytes, predicts every echo,
// erase and line replay byte, and checks each transmit transfer against the prediction.
// Depends on uled_pkg and the uart_line_editor_echo_core RTL.
`timescale 1ns / 1ps

module uart_line_editor_echo_core_tb;
    import uled_pkg::*;

    localparam int LINE_LEN     = LINE_LEN_DEF;
    localparam int RAND_ITEMS   = 230;
    localparam int SETTLE       = 50;
    localparam int HOLD_CYCLES  = 400;
    localparam int STALL_LIMIT  = 4000;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              copy;
        logic              last;
    } tx_item_t;

    class echo_tracker;
        logic [BYTE_W-1:0] line_mem [0:LINE_LEN];
        int unsigned       line_idx;
        tx_item_t          pending_tx [$];
        int                errors;

        function new();
            line_idx = 0;
            errors   = 0;
            foreach (line_mem[i]) line_mem[i] = '0;
        endfunction

        function void add_tx(logic [BYTE_W-1:0] d, logic c);
            tx_item_t t;
            t.data = d;
            t.copy = c;
            t.last = 1'b0;
            pending_tx.push_back(t);
        endfunction

        function void take_rx_byte(logic [BYTE_W-1:0] b);
            tx_item_t t;
            int       i;
            if (line_idx == 0) begin
                foreach (line_mem[n]) line_mem[n] = '0;
            end
            if (b == CODE_CR) begin
                line_mem[line_idx] = b;
                line_idx = 0;
                add_tx(CODE_LF, 1'b0);
                add_tx(CODE_CR, 1'b0);
                for (i = 0; i <= LINE_LEN; i++) begin
                    if (line_mem[i] == '0) break;
                    add_tx(line_mem[i], 1'b1);
                end
                add_tx(CODE_CR, 1'b1);
                add_tx(CODE_LF, 1'b1);
            end else if (b == CODE_BS && line_idx > 0) begin
                line_mem[line_idx] = '0;
                line_idx--;
                add_tx(CODE_BS, 1'b0);
                add_tx(CODE_SP, 1'b0);
                add_tx(CODE_SP, 1'b0);
                add_tx(CODE_BS, 1'b0);
                add_tx(b, 1'b0);
            end else begin
                if (line_idx < LINE_LEN) begin
                    line_mem[line_idx] = b;
                    line_idx++;
                end
                add_tx(b, 1'b0);
            end
            t = pending_tx.pop_back();
            t.last = 1'b1;
            pending_tx.push_back(t);
        endfunction

        function void check_tx(logic [BYTE_W-1:0] d, logic c, logic l);
            tx_item_t e;
            if (pending_tx.size() == 0) begin
                $error("tx_byte %02h arrived with no result pending", d);
                errors++;
                return;
            end
            e = pending_tx.pop_front();
            if (d !== e.data) begin
                $error("tx_byte: expected %02h, got %02h", e.data, d);
                errors++;
            end
            if (c !== e.copy) begin
                $error("line_copy: expected %0b, got %0b", e.copy, c);
                errors++;
            end
            if (l !== e.last) begin
                $error("last_of_run: expected %0b, got %0b", e.last, l);
                errors++;
            end
        endfunction

        function int pending();
            return pending_tx.size();
        endfunction
    endclass

    logic              i_clk;
    logic              i_rst_n;
    logic              i_rx_valid;
    logic              o_rx_ready;
    logic [BYTE_W-1:0] i_rx_byte;
    logic              o_tx_valid;
    logic              i_tx_ready;
    logic [BYTE_W-1:0] o_tx_byte;
    logic              o_line_copy;
    logic              o_last_of_run;

    echo_tracker board;
    logic        calm;
    logic        hold_tx;
    int          stall_cnt;

    uart_line_editor_echo_core #(
        .LINE_LEN(LINE_LEN)
    ) uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_rx_valid   (i_rx_valid),
        .o_rx_ready   (o_rx_ready),
        .i_rx_byte    (i_rx_byte),
        .o_tx_valid   (o_tx_valid),
        .i_tx_ready   (i_tx_ready),
        .o_tx_byte    (o_tx_byte),
        .o_line_copy  (o_line_copy),
        .o_last_of_run(o_last_of_run)
    );

    initial begin
        i_clk = 1'b0;
    end

    always #5 i_clk = ~i_clk;

    task automatic send_rx(input logic [BYTE_W-1:0] b);
        while (!calm && $urandom_range(99) < 16) begin
            i_rx_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_rx_valid <= 1'b1;
        i_rx_byte  <= b;
        do @(posedge i_clk); while (!o_rx_ready);
        board.take_rx_byte(b);
    endtask

    task automatic drain();
        i_rx_valid <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    initial begin
        i_tx_ready = 1'b0;
        @(posedge i_clk);
        forever begin
            if (hold_tx) begin
                i_tx_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_tx = 1'b0;
            end
            i_tx_ready <= calm || ($urandom_range(99) >= 16);
            @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_tx_valid && i_tx_ready) begin
            board.check_tx(o_tx_byte, o_line_copy, o_last_of_run);
        end
    end

    always @(posedge i_clk) begin
        if ((i_rx_valid && o_rx_ready) || (o_tx_valid && i_tx_ready)) begin
            stall_cnt <= 0;
        end else begin
            stall_cnt <= stall_cnt + 1;
        end
        if (stall_cnt >= STALL_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        logic [BYTE_W-1:0] directed [$];
        logic [BYTE_W-1:0] b;
        int                sent;
        int                line_no;
        int                len;
        int                j;
        int unsigned       r;
        logic              fill;

        board      = new();
        stall_cnt  = 0;
        calm       = 1'b0;
        hold_tx    = 1'b0;
        i_rst_n    = 1'b0;
        i_rx_valid = 1'b0;
        i_rx_byte  = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // A typed zero byte cuts a later replay short, a backspace at index zero is stored.
        directed = '{8'h41, 8'hFF, 8'h00, CODE_BS, 8'h7E, CODE_CR,
                     CODE_BS, 8'h78, CODE_CR,
                     CODE_CR,
                     8'h80, 8'h01, 8'h00, 8'h55, CODE_CR,
                     8'h71, CODE_BS, CODE_BS, 8'hAA, CODE_CR};
        foreach (directed[n]) send_rx(directed[n]);
        drain();

        sent    = 0;
        line_no = 0;
        while (sent < RAND_ITEMS) begin
            calm = (line_no >= 12 && line_no < 20);
            if (line_no == 4) hold_tx = 1'b1;
            fill = (line_no == 0) || ($urandom_range(9) == 0);
            if (fill) len = $urandom_range(LINE_LEN + 4, LINE_LEN - 2);
            else len = $urandom_range(12);
            for (j = 0; j < len; j++) begin
                r = $urandom_range(99);
                if (line_no == 0) begin
                    b = 8'($urandom_range(255));
                    if (b == 8'h00 || b == CODE_BS || b == CODE_CR) b = 8'h41;
                end else if (r < 10) begin
                    b = CODE_BS;
                end else if (r < 13) begin
                    b = 8'h00;
                end else begin
                    b = 8'($urandom_range(255));
                end
                send_rx(b);
                sent++;
            end
            if ($urandom_range(9) != 0) begin
                send_rx(CODE_CR);
                sent++;
            end
            line_no++;
        end
        calm = 1'b0;
        drain();

        if (board.errors == 0 && board.pending() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
